>>> hw/rtl/nghri_pkg.sv
// shared constants, types and codes for the n-gram hash row indexer
`timescale 1ns / 1ps
package nghri_pkg;
    localparam int MaxNgram      = 4;
    localparam int Heads         = 8;
    localparam int MapEntries    = 131072;
    localparam int LayerSlots    = 4;
    localparam int HistDepth     = MaxNgram - 1;
    localparam int SlotsPerLayer = (MaxNgram - 1) * Heads;
    localparam int MapAw         = $clog2(MapEntries);
    localparam int LsW           = (LayerSlots > 1) ? $clog2(LayerSlots) : 1;
    localparam int KW            = $clog2(MaxNgram);
    localparam int ColW          = $clog2(SlotsPerLayer);
    localparam int HeadW         = (Heads > 1) ? $clog2(Heads) : 1;
    localparam int SeenW         = $clog2(MaxNgram);
    localparam int MulDepth      = LayerSlots * MaxNgram;
    localparam int PrDepth       = LayerSlots * SlotsPerLayer;
    localparam int MulAw         = $clog2(MulDepth);
    localparam int PrAw          = $clog2(PrDepth);

    localparam logic [2:0] FUNC_TOKEN  = 3'd0;
    localparam logic [2:0] FUNC_MAP    = 3'd1;
    localparam logic [2:0] FUNC_MULT   = 3'd2;
    localparam logic [2:0] FUNC_PRIME  = 3'd3;
    localparam logic [2:0] FUNC_OFFSET = 3'd4;
    localparam logic [2:0] FUNC_ROWS   = 3'd5;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_MAP   = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    localparam logic CFG_PAD = 1'b0;
    localparam logic CFG_MAP = 1'b1;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] rem;
    } div_rsp_t;
endpackage

>>> hw/rtl/nghri_div.sv
// shared iterative unit: truncating signed remainder, one bit a cycle
`timescale 1ns / 1ps
module nghri_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  nghri_pkg::div_req_t req,
    output nghri_pkg::div_rsp_t rsp
);
    import nghri_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic [64:0] diff;
    logic [63:0] rem_out;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[63:0], quo_reg[63]};
        diff      = shifted - {1'b0, den_reg};
        if (req.start) begin
            neg_next  = req.num[63];
            quo_next  = req.num[63] ? (64'd0 - req.num) : req.num;
            den_next  = req.den[63] ? (64'd0 - req.den) : req.den;
            rem_next  = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[62:0], 1'b0};
            rem_next = diff[64] ? shifted : diff;
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rem_out  = rem_reg[63:0];
    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = neg_reg ? (64'd0 - rem_out) : rem_out;
endmodule

>>> hw/rtl/nghri_tables.sv
// loaded tables: compression map, multipliers, primes, offsets
`timescale 1ns / 1ps
module nghri_tables (
    input  logic                         aclk,
    input  logic                         map_we,
    input  logic [nghri_pkg::MapAw-1:0]  map_waddr,
    input  logic [31:0]                  map_wdata,
    input  logic [nghri_pkg::MapAw-1:0]  map_raddr,
    output logic [31:0]                  map_rdata,
    input  logic                         mul_we,
    input  logic [nghri_pkg::MulAw-1:0]  mul_waddr,
    input  logic [nghri_pkg::MulAw-1:0]  mul_raddr,
    output logic [63:0]                  mul_rdata,
    input  logic                         pr_we,
    input  logic                         off_we,
    input  logic [nghri_pkg::PrAw-1:0]   pr_waddr,
    input  logic [nghri_pkg::PrAw-1:0]   pr_raddr,
    output logic [63:0]                  pr_rdata,
    output logic [63:0]                  off_rdata,
    input  logic [63:0]                  wdata
);
    import nghri_pkg::*;

    logic [31:0] map_mem [MapEntries];
    logic [63:0] mul_mem [MulDepth];
    logic [63:0] pr_mem  [PrDepth];
    logic [63:0] off_mem [PrDepth];

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rdata <= map_mem[map_raddr];
    end

    always_ff @(posedge aclk) begin
        if (mul_we) begin
            mul_mem[mul_waddr] <= wdata;
        end
        mul_rdata <= mul_mem[mul_raddr];
    end

    always_ff @(posedge aclk) begin
        if (pr_we) begin
            pr_mem[pr_waddr] <= wdata;
        end
        pr_rdata <= pr_mem[pr_raddr];
    end

    always_ff @(posedge aclk) begin
        if (off_we) begin
            off_mem[pr_waddr] <= wdata;
        end
        off_rdata <= off_mem[pr_raddr];
    end
endmodule

>>> hw/rtl/ngram_hash_row_indexer_unit.sv
// top level of the n-gram hash row indexer: sequencer, history and result register
//
//  channel | dir | handshake              | payload
//  s_axis  | in  | s_tvalid / s_tready    | s_tdata, s_tuser (func)
//  cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  m_axis  | out | m_tvalid / m_tready    | m_tdata, m_tuser (error), m_tlast
//
// a token is accepted, then the map is read; each look-back takes a table read, three
// passes of the shared 32x32 multiplier and a fold, and each row takes a prime read,
// a 64-step remainder plus done and an add (both skipped for a zero prime) and output
// a token that hits the map or layer error gives a single error result; loads and
// ignored funcs are taken in the idle state and can follow each other with no gap
// aresetn is synchronous, active low; it clears history and handshake state,
// tables stay undefined until loaded
// a stalled result holds the sequencer; s_tready is low while a token is in work
`timescale 1ns / 1ps
module ngram_hash_row_indexer_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: layer_slot[1:0], token_id[33:2], seq_start[34], table_index[51:35],
    //        load_value[115:52], zero fill to 120
    input  logic [119:0] s_tdata,
    input  logic [2:0]   s_tuser,   // func
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: row_index[39:0], slot[44:40], zero fill to 48
    output logic [47:0]  m_tdata,
    output logic [1:0]   m_tuser,   // error_code
    output logic         m_tlast    // last_row
);
    import nghri_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MAPRD, S_MAPWT, S_MUL, S_MULWT, S_MP0, S_MP1, S_MP2, S_FOLD,
        S_PRRD, S_PRWT, S_DIV, S_DIVWT, S_ADD, S_OUT, S_ERR
    } state_t;

    state_t      state_reg;
    logic [1:0]  ls_reg;
    logic [31:0] tok_reg;
    logic        start_reg;
    logic [KW-1:0]   k_reg;
    logic [HeadW-1:0] h_reg;
    logic [ColW-1:0]  col_reg;
    logic [63:0] fold_reg;
    logic [63:0] prod_reg;
    logic [63:0] mula_reg;
    logic [63:0] mulb_reg;
    logic [63:0] prime_reg;
    logic [63:0] rem_reg;
    logic [32:0] cur_reg;
    logic [32:0] hist_reg [HistDepth];
    logic [SeenW-1:0] seen_reg;
    logic        blocked_reg;
    logic [31:0] pad_reg;
    logic [17:0] mapuse_reg;
    logic [39:0] rows_reg [LayerSlots];
    logic        out_valid_reg;
    logic [39:0] out_row_reg;
    logic [4:0]  out_slot_reg;
    logic        out_last_reg;
    logic [1:0]  out_err_reg;
    logic [1:0]  err_code_reg;

    logic [1:0]  in_ls;
    logic [31:0] in_tok;
    logic        in_start;
    logic [16:0] in_idx;
    logic [63:0] in_val;
    logic        s_fire;
    logic        ls_ok;
    logic [31:0] map_rdata;
    logic [63:0] mul_rdata, pr_rdata, off_rdata;
    logic [MulAw-1:0] mul_addr;
    logic [PrAw-1:0]  pr_addr;
    logic [32:0] ent;
    logic        blk;
    logic [63:0] id64;
    logic [63:0] row_sum;
    logic [31:0] mul_opa, mul_opb;
    logic [63:0] mul_prod;
    logic        tok_in_map;
    logic        win_bad;
    logic        out_load;
    div_req_t    dreq;
    div_rsp_t    drsp;

    assign in_ls    = s_tdata[1:0];
    assign in_tok   = s_tdata[33:2];
    assign in_start = s_tdata[34];
    assign in_idx   = s_tdata[51:35];
    assign in_val   = s_tdata[115:52];
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign ls_ok    = ({30'd0, in_ls} < LayerSlots);

    // load path straight from the input transfer
    logic map_we, mul_we, pr_we, off_we;
    assign map_we = s_fire && s_tuser == FUNC_MAP && {15'd0, in_idx} < MapEntries;
    assign mul_we = s_fire && s_tuser == FUNC_MULT && ls_ok && {15'd0, in_idx} < MaxNgram;
    assign pr_we  = s_fire && s_tuser == FUNC_PRIME && ls_ok
                  && {15'd0, in_idx} < SlotsPerLayer;
    assign off_we = s_fire && s_tuser == FUNC_OFFSET && ls_ok
                  && {15'd0, in_idx} < SlotsPerLayer;

    assign mul_addr = (state_reg == S_IDLE)
                    ? MulAw'(in_ls * MaxNgram + int'(in_idx[KW-1:0]))
                    : MulAw'(ls_reg * MaxNgram + int'(k_reg));
    assign pr_addr  = (state_reg == S_IDLE)
                    ? PrAw'(in_ls * SlotsPerLayer + int'(in_idx[ColW-1:0]))
                    : PrAw'(ls_reg * SlotsPerLayer + int'(col_reg));

    nghri_tables u_tables (
        .aclk      (aclk),
        .map_we    (map_we),
        .map_waddr (in_idx[MapAw-1:0]),
        .map_wdata (in_val[31:0]),
        .map_raddr (tok_reg[MapAw-1:0]),
        .map_rdata (map_rdata),
        .mul_we    (mul_we),
        .mul_waddr (mul_addr),
        .mul_raddr (mul_addr),
        .mul_rdata (mul_rdata),
        .pr_we     (pr_we),
        .off_we    (off_we),
        .pr_waddr  (pr_addr),
        .pr_raddr  (pr_addr),
        .pr_rdata  (pr_rdata),
        .off_rdata (off_rdata),
        .wdata     (in_val)
    );

    nghri_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign dreq = '{start: (state_reg == S_DIV), num: fold_reg, den: prime_reg};

    // id for the current look-back, pad once any shorter one is padded
    always_comb begin
        ent  = (k_reg == '0) ? cur_reg : hist_reg[k_reg - 1'b1];
        blk  = blocked_reg || ({1'b0, k_reg} > {1'b0, seen_reg});
        id64 = blk ? {{32{pad_reg[31]}}, pad_reg} : {{32{ent[31]}}, ent[31:0]};
    end

    // current token in the map, and any unpadded id in the window outside it
    always_comb begin
        tok_in_map = ({14'd0, tok_reg} < {28'd0, mapuse_reg})
                  && ({14'd0, tok_reg} < 46'(MapEntries));
        win_bad = !tok_in_map;
        for (int j = 0; j < HistDepth; j++) begin
            if (j < int'(seen_reg) && hist_reg[j][32]) win_bad = 1'b1;
        end
    end

    // 64-bit wrapped product in three passes: lo*lo, lo*hi, hi*lo
    assign mul_opa  = (state_reg == S_MP2) ? mula_reg[63:32] : mula_reg[31:0];
    assign mul_opb  = (state_reg == S_MP1) ? mulb_reg[63:32] : mulb_reg[31:0];
    assign mul_prod = {32'd0, mul_opa} * {32'd0, mul_opb};

    assign row_sum = rem_reg + off_rdata;

    // result register takes a new transfer when empty or draining
    assign out_load = (state_reg == S_OUT || state_reg == S_ERR)
                   && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            seen_reg      <= '0;
            pad_reg       <= '0;
            mapuse_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HistDepth; i++) hist_reg[i] <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_PAD) pad_reg <= cfg_data;
                else mapuse_reg <= cfg_data[17:0];
            end
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        ls_reg    <= in_ls;
                        tok_reg   <= in_tok;
                        start_reg <= in_start;
                        if (s_tuser == FUNC_TOKEN) state_reg <= S_MAPRD;
                        if (s_tuser == FUNC_ROWS && ls_ok) rows_reg[in_ls] <= in_val[39:0];
                    end
                end
                S_MAPRD: begin
                    if (start_reg) seen_reg <= '0;
                    state_reg <= S_MAPWT;
                end
                S_MAPWT: begin
                    if (tok_in_map)
                        cur_reg <= {1'b0, map_rdata};
                    else
                        cur_reg <= {1'b1, 32'd0};
                    k_reg       <= '0;
                    blocked_reg <= 1'b0;
                    fold_reg    <= '0;
                    col_reg     <= '0;
                    h_reg       <= '0;
                    if ({30'd0, ls_reg} >= LayerSlots) begin
                        err_code_reg <= ERR_RANGE;
                        state_reg    <= S_ERR;
                    end else if (win_bad) begin
                        err_code_reg <= ERR_MAP;
                        state_reg    <= S_ERR;
                    end else begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: state_reg <= S_MULWT;
                S_MULWT: begin
                    blocked_reg <= blk;
                    mula_reg    <= id64;
                    mulb_reg    <= mul_rdata;
                    state_reg   <= S_MP0;
                end
                S_MP0: begin
                    prod_reg  <= mul_prod;
                    state_reg <= S_MP1;
                end
                S_MP1: begin
                    prod_reg  <= prod_reg + {mul_prod[31:0], 32'd0};
                    state_reg <= S_MP2;
                end
                S_MP2: begin
                    prod_reg  <= prod_reg + {mul_prod[31:0], 32'd0};
                    state_reg <= S_FOLD;
                end
                S_FOLD: begin
                    fold_reg <= fold_reg ^ prod_reg;
                    h_reg    <= '0;
                    if (k_reg == '0) begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_MUL;
                    end else begin
                        state_reg <= S_PRRD;
                    end
                end
                S_PRRD: state_reg <= S_PRWT;
                S_PRWT: begin
                    prime_reg <= pr_rdata;
                    state_reg <= (pr_rdata == 64'd0) ? S_OUT : S_DIV;
                    rem_reg   <= '0;
                end
                S_DIV: state_reg <= S_DIVWT;
                S_DIVWT: begin
                    if (drsp.done) begin
                        rem_reg   <= drsp.rem;
                        state_reg <= S_ADD;
                    end
                end
                S_ADD: begin
                    rem_reg   <= row_sum;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        out_slot_reg  <= 5'(col_reg);
                        out_last_reg  <= (int'(col_reg) == SlotsPerLayer - 1);
                        if (prime_reg == 64'd0 || rem_reg[63]
                            || rem_reg >= {24'd0, rows_reg[ls_reg]}) begin
                            out_err_reg <= ERR_RANGE;
                            out_row_reg <= '0;
                        end else begin
                            out_err_reg <= ERR_OK;
                            out_row_reg <= rem_reg[39:0];
                        end
                        col_reg <= col_reg + 1'b1;
                        if (int'(h_reg) == Heads - 1) begin
                            if (int'(k_reg) == MaxNgram - 1) begin
                                state_reg <= S_IDLE;
                                for (int i = HistDepth - 1; i > 0; i--)
                                    hist_reg[i] <= hist_reg[i-1];
                                hist_reg[0] <= cur_reg;
                                if (int'(seen_reg) < HistDepth) seen_reg <= seen_reg + 1'b1;
                            end else begin
                                k_reg     <= k_reg + 1'b1;
                                state_reg <= S_MUL;
                            end
                        end else begin
                            h_reg     <= h_reg + 1'b1;
                            state_reg <= S_PRRD;
                        end
                    end
                end
                S_ERR: begin
                    if (out_load) begin
                        out_slot_reg  <= '0;
                        out_last_reg  <= 1'b1;
                        out_err_reg   <= err_code_reg;
                        out_row_reg   <= '0;
                        state_reg     <= S_IDLE;
                        for (int i = HistDepth - 1; i > 0; i--)
                            hist_reg[i] <= hist_reg[i-1];
                        hist_reg[0] <= cur_reg;
                        if (int'(seen_reg) < HistDepth) seen_reg <= seen_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_slot_reg, out_row_reg};
    assign m_tuser  = out_err_reg;
    assign m_tlast  = out_last_reg;
endmodule

>>> hw/rtl/nghri_checker.sv
// port-level checks for the row indexer, bound to the top level
`timescale 1ns / 1ps
module nghri_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [47:0]  m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != 2'd0 |-> m_tdata[39:0] == 40'd0)
        else $error("error result with nonzero row");
    a_map_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == 2'd1 |-> m_tlast && m_tdata[44:40] == 5'd0)
        else $error("map error not a single result");
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("unknown error code");
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid)
        else $error("input transfer withdrawn while waiting");
endmodule

bind ngram_hash_row_indexer_unit nghri_checker u_nghri_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
);
